[rtl/core/gpsp_pkg.sv]
// ----------------------------------------------------------------------------
// Gamepad serial poll host package
// Shared types, codes and constants of the gamepad link host.
// ----------------------------------------------------------------------------
package gpsp_pkg;

	localparam int FRAME_BYTES = 9;
	// Received bytes kept for the report; fixed by the report layout.
	localparam int RX_BYTES = 9;
	localparam int BYTE_IDX_W = 4;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = 2;
	localparam int AXES = 4;

	// Request command codes.
	localparam logic [1:0] CMD_TICK = 2'd0;
	localparam logic [1:0] CMD_POLL = 2'd1;
	localparam logic [1:0] CMD_VIBE = 2'd2;
	localparam logic [1:0] CMD_INIT = 2'd3;

	// Configuration register indexes.
	localparam logic [2:0] REG_DEADZONE = 3'd0;
	localparam logic [2:0] REG_DZ_ENABLE = 3'd1;
	localparam logic [2:0] REG_SETUP = 3'd2;
	localparam logic [2:0] REG_SAMPLE = 3'd3;
	localparam logic [2:0] REG_HOLD = 3'd4;
	localparam logic [2:0] REG_GUARD = 3'd5;

	localparam logic [7:0] AXIS_CENTER = 8'd128;
	localparam logic [7:0] AXIS_SPAN = 8'd127;

	typedef struct packed {
		logic [6:0] deadzone;
		logic       deadzone_enable;
		logic [7:0] setup_ticks;
		logic [7:0] sample_ticks;
		logic [7:0] hold_ticks;
		logic [9:0] select_guard_ticks;
	} cfg_t;

	// One tick's report as it leaves the sequencer, axes still raw.
	typedef struct packed {
		logic                 select_n;
		logic                 serial_clock;
		logic                 command_line;
		logic                 busy;
		logic                 done;
		logic [7:0]           mode;
		logic [7:0]           btn_lo;
		logic [7:0]           btn_hi;
		logic [AXES-1:0][7:0] axis;
	} rec_t;

	// Command bytes of the seven init frames.
	function automatic logic [7:0] init_byte(input logic [2:0] step,
			input logic [BYTE_IDX_W-1:0] idx);
		logic [2:0] s;
		logic [7:0] b;
		s = (step == 3'd7) ? 3'd6 : step;
		b = 8'h00;
		if (idx == 4'd0) begin
			b = 8'h01;
		end else if (idx == 4'd1) begin
			unique case (s)
				3'd3, 3'd6: b = 8'h43;
				3'd4: b = 8'h44;
				3'd5: b = 8'h4D;
				default: b = 8'h42;
			endcase
		end else if (idx == 4'd3) begin
			b = (s == 3'd3 || s == 3'd4) ? 8'h01 : 8'h00;
		end else if (idx == 4'd4) begin
			if (s == 3'd4) b = 8'hEE;
			else if (s == 3'd5) b = 8'h01;
			else if (s == 3'd6) b = 8'h5A;
		end else if (idx >= 4'd5 && idx <= 4'd8) begin
			b = (s == 3'd6) ? 8'h5A : 8'h00;
		end
		return b;
	endfunction

endpackage

[rtl/core/gpsp_if.sv]
// ----------------------------------------------------------------------------
// Gamepad serial poll host channels
// Valid/ready channels for tick requests and tick reports.
// ----------------------------------------------------------------------------
interface gpsp_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [7:0] motor_large;
	logic [7:0] motor_small;
	logic       data_in;
	modport source(output valid, command, motor_large, motor_small, data_in, input ready);
	modport sink(input valid, command, motor_large, motor_small, data_in, output ready);
endinterface

interface gpsp_rsp_if;
	logic       valid;
	logic       ready;
	logic       select_n;
	logic       serial_clock;
	logic       command_line;
	logic       busy_res;
	logic       done_res;
	logic [7:0] mode_byte;
	logic [7:0] buttons_low;
	logic [7:0] buttons_high;
	logic [7:0] right_x;
	logic [7:0] right_y;
	logic [7:0] left_x;
	logic [7:0] left_y;
	modport source(output valid, select_n, serial_clock, command_line, busy_res, done_res,
		mode_byte, buttons_low, buttons_high, right_x, right_y, left_x, left_y,
		input ready);
	modport sink(input valid, select_n, serial_clock, command_line, busy_res, done_res,
		mode_byte, buttons_low, buttons_high, right_x, right_y, left_x, left_y,
		output ready);
endinterface

[rtl/core/gpsp_seq.sv]
// ----------------------------------------------------------------------------
// Gamepad link sequencer
// Takes one tick request per cycle unless the queue is full, drives the pin levels and collects bytes.
// ----------------------------------------------------------------------------
module gpsp_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  gpsp_pkg::cfg_t cfg,
	gpsp_req_if.sink       req,
	input  logic           q_full,
	output logic           q_push,
	output gpsp_pkg::rec_t q_rec
);
	import gpsp_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE, PH_SEL, PH_LEAD, PH_HIGH, PH_LOW, PH_HOLD, PH_DESEL
	} phase_t;

	phase_t                phase_q, ph, ph_n;
	logic [9:0]            tick_q, tick, tick_n, len;
	logic [2:0]            bit_q, bitx, bit_n;
	logic [BYTE_IDX_W-1:0] byte_q, bytex, byte_n, flen;
	logic [2:0]            step_q, step, step_n;
	logic [1:0]            op_q, op;
	logic [15:0]           motor_q, motor;
	logic [7:0]            shift_q, shift, shift_n, cmdb;
	logic [7:0]            rb_q [RX_BYTES];
	logic                  start, last, rb_we, take;

	assign req.ready = !q_full;
	assign take = req.valid && !q_full;
	assign q_push = take;

	// Next-state and pin levels for the current tick.
	always_comb begin
		start = (phase_q == PH_IDLE) && (req.command != CMD_TICK);
		ph = start ? PH_SEL : phase_q;
		tick = start ? 10'd0 : tick_q;
		bitx = start ? 3'd0 : bit_q;
		bytex = start ? '0 : byte_q;
		step = start ? 3'd0 : step_q;
		shift = start ? 8'd0 : shift_q;
		op = start ? req.command : op_q;
		motor = start ? {req.motor_small, req.motor_large} : motor_q;

		// Command byte in flight.
		if (op == CMD_INIT) cmdb = init_byte(step, bytex);
		else if (bytex == 4'd0) cmdb = 8'h01;
		else if (bytex == 4'd1) cmdb = 8'h42;
		else if (op == CMD_VIBE && bytex == 4'd3) cmdb = motor[7:0];
		else if (op == CMD_VIBE && bytex == 4'd4) cmdb = motor[15:8];
		else cmdb = 8'h00;

		unique case (ph)
			PH_SEL, PH_DESEL: len = cfg.select_guard_ticks;
			PH_LEAD, PH_HIGH: len = {2'b00, cfg.setup_ticks};
			PH_LOW: len = {2'b00, cfg.sample_ticks};
			default: len = {2'b00, cfg.hold_ticks};
		endcase
		if (len == 10'd0) len = 10'd1;
		last = ({1'b0, tick} + 11'd1) >= {1'b0, len};

		ph_n = ph;
		tick_n = last ? 10'd0 : tick + 10'd1;
		bit_n = bitx;
		byte_n = bytex;
		step_n = step;
		shift_n = shift;
		rb_we = 1'b0;
		flen = (op == CMD_INIT && (step <= 3'd2 || step == 3'd5)) ? 4'd5 : 4'(FRAME_BYTES);
		q_rec = '0;
		if (last) begin
			unique case (ph)
				PH_IDLE: ph_n = PH_IDLE;
				PH_SEL: ph_n = PH_LEAD;
				PH_LEAD: begin
					ph_n = PH_HIGH;
					bit_n = 3'd0;
					shift_n = 8'd0;
				end
				PH_HIGH: ph_n = PH_LOW;
				PH_LOW: begin
					shift_n = shift | (8'(req.data_in) << bitx);
					ph_n = PH_HOLD;
				end
				PH_HOLD: begin
					if (bitx != 3'd7) begin
						bit_n = bitx + 3'd1;
						ph_n = PH_HIGH;
					end else begin
						rb_we = (op != CMD_INIT) && (bytex < 4'(RX_BYTES));
						byte_n = bytex + 4'd1;
						bit_n = 3'd0;
						ph_n = (byte_n >= flen) ? PH_DESEL : PH_LEAD;
					end
				end
				PH_DESEL: begin
					if (op == CMD_INIT && step < 3'd6) begin
						step_n = step + 3'd1;
						byte_n = '0;
						ph_n = PH_SEL;
					end else begin
						ph_n = PH_IDLE;
						q_rec.done = 1'b1;
					end
				end
				default: ph_n = PH_IDLE;
			endcase
		end
		if (ph == PH_IDLE) tick_n = tick;

		// Report record; bytes reflect the write made on this tick.
		q_rec.select_n = !(ph != PH_IDLE && ph != PH_DESEL);
		q_rec.serial_clock = !(ph == PH_LOW || ph == PH_HOLD);
		q_rec.command_line = (ph == PH_HIGH || ph == PH_LOW || ph == PH_HOLD) && cmdb[bitx];
		q_rec.busy = (ph != PH_IDLE);
		q_rec.mode = (rb_we && bytex == 4'd1) ? shift : rb_q[1];
		q_rec.btn_lo = ~((rb_we && bytex == 4'd3) ? shift : rb_q[3]);
		q_rec.btn_hi = ~((rb_we && bytex == 4'd4) ? shift : rb_q[4]);
		for (int a = 0; a < AXES; a++) begin
			q_rec.axis[a] = (rb_we && bytex == 4'(a + 5)) ? shift : rb_q[a + 5];
		end
	end

	// Sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q <= '0;
			bit_q <= '0;
			byte_q <= '0;
			step_q <= '0;
			op_q <= '0;
			motor_q <= '0;
			shift_q <= '0;
			for (int i = 0; i < RX_BYTES; i++) rb_q[i] <= '0;
		end else if (take) begin
			phase_q <= ph_n;
			tick_q <= tick_n;
			bit_q <= bit_n;
			byte_q <= byte_n;
			step_q <= step_n;
			op_q <= op;
			motor_q <= motor;
			shift_q <= shift_n;
			if (rb_we) rb_q[bytex] <= shift;
		end
	end

endmodule

[rtl/core/gpsp_queue.sv]
// ----------------------------------------------------------------------------
// Gamepad link report queue
// Short FIFO between the sequencer and the axis remap stage.
// ----------------------------------------------------------------------------
module gpsp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  gpsp_pkg::rec_t wr_rec,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output gpsp_pkg::rec_t rd_rec
);
	import gpsp_pkg::*;

	rec_t                   mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_q, rd_q;
	logic [QUEUE_PTR_W:0]   cnt_q;

	assign full = (cnt_q == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign rd_rec = mem_q[rd_q];

	// Storage.
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wr_rec;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

[rtl/core/gpsp_remap.sv]
// ----------------------------------------------------------------------------
// Gamepad link axis remap
// Applies the stick deadzone with a cached result and a serial divider.
// ----------------------------------------------------------------------------
module gpsp_remap (
	input  logic           clk,
	input  logic           arst_n,
	input  gpsp_pkg::cfg_t cfg,
	input  logic           q_empty,
	input  gpsp_pkg::rec_t q_rec,
	output logic           q_pop,
	gpsp_rsp_if.source     rsp
);
	import gpsp_pkg::*;

	typedef enum logic [1:0] {B_RUN, B_LOAD, B_DIV} bstate_t;

	bstate_t              st_q;
	logic [AXES-1:0][7:0] key_q, val_q;
	logic [6:0]           key_d_q;
	logic                 key_en_q, key_ok_q, hit, can_load;
	logic [1:0]           ax_q;
	logic [14:0]          num_q;
	logic [7:0]           den_q;
	logic [7:0]           rem_q;
	logic [3:0]           cnt_q;
	logic                 hi_q;
	logic [7:0]           v;
	logic [8:0]           lo_lim, hi_lim, trial;
	logic [7:0]           over;
	rec_t                 out_q;
	logic                 out_v_q;

	assign hit = key_ok_q && (key_q == q_rec.axis) && (key_d_q == cfg.deadzone)
		&& (key_en_q == cfg.deadzone_enable);
	assign can_load = !out_v_q || rsp.ready;
	assign q_pop = (st_q == B_RUN) && !q_empty && hit && can_load;

	// Axis classification for the axis being computed.
	always_comb begin
		v = q_rec.axis[ax_q];
		hi_lim = {1'b0, AXIS_CENTER} + {2'b00, cfg.deadzone};
		lo_lim = {1'b0, v} + {2'b00, cfg.deadzone};
		over = v - AXIS_CENTER - {1'b0, cfg.deadzone};
		trial = {rem_q, num_q[14]};
	end

	// Cache control, serial divider and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_RUN;
			key_ok_q <= 1'b0;
			out_v_q <= 1'b0;
			out_q <= '0;
			ax_q <= '0;
			cnt_q <= '0;
			num_q <= '0;
			den_q <= '0;
			rem_q <= '0;
			hi_q <= 1'b0;
			key_q <= '0;
			val_q <= '0;
			key_d_q <= '0;
			key_en_q <= 1'b0;
		end else begin
			if (rsp.ready) out_v_q <= 1'b0;
			unique case (st_q)
				B_RUN: begin
					if (q_pop) begin
						out_q <= q_rec;
						out_q.axis <= val_q;
						out_v_q <= 1'b1;
					end else if (!q_empty && !hit) begin
						ax_q <= '0;
						st_q <= B_LOAD;
					end
				end
				B_LOAD: begin
					// Pick the remap branch; only the outer bands divide.
					st_q <= B_RUN;
					if (!cfg.deadzone_enable) begin
						val_q[ax_q] <= v;
					end else if ({1'b0, v} > hi_lim) begin
						if (cfg.deadzone == 7'd127) begin
							val_q[ax_q] <= 8'd255;
						end else begin
							num_q <= {over, 7'd0} - {7'd0, over};
							den_q <= AXIS_SPAN - {1'b0, cfg.deadzone};
							hi_q <= 1'b1;
							rem_q <= '0;
							cnt_q <= '0;
							st_q <= B_DIV;
						end
					end else if (lo_lim < {1'b0, AXIS_CENTER}) begin
						num_q <= {v, 7'd0};
						den_q <= AXIS_CENTER - {1'b0, cfg.deadzone};
						hi_q <= 1'b0;
						rem_q <= '0;
						cnt_q <= '0;
						st_q <= B_DIV;
					end else begin
						val_q[ax_q] <= AXIS_CENTER;
					end
					if (st_q == B_LOAD && !(cfg.deadzone_enable
							&& ({1'b0, v} > hi_lim && cfg.deadzone != 7'd127
							|| !({1'b0, v} > hi_lim) && lo_lim < {1'b0, AXIS_CENTER}))) begin
						if (ax_q == 2'(AXES - 1)) begin
							key_q <= q_rec.axis;
							key_d_q <= cfg.deadzone;
							key_en_q <= cfg.deadzone_enable;
							key_ok_q <= 1'b1;
						end else begin
							ax_q <= ax_q + 2'd1;
							st_q <= B_LOAD;
						end
					end
				end
				B_DIV: begin
					// One restoring-division step; quotient bits fill num_q.
					if (trial >= {1'b0, den_q}) begin
						rem_q <= 8'(trial - {1'b0, den_q});
						num_q <= {num_q[13:0], 1'b1};
					end else begin
						rem_q <= trial[7:0];
						num_q <= {num_q[13:0], 1'b0};
					end
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) begin
						val_q[ax_q] <= hi_q ? AXIS_CENTER + num_q[7:0] : num_q[7:0];
						if (ax_q == 2'(AXES - 1)) begin
							key_q <= q_rec.axis;
							key_d_q <= cfg.deadzone;
							key_en_q <= cfg.deadzone_enable;
							key_ok_q <= 1'b1;
							st_q <= B_RUN;
						end else begin
							ax_q <= ax_q + 2'd1;
							st_q <= B_LOAD;
						end
					end
				end
				default: st_q <= B_RUN;
			endcase
		end
	end

	assign rsp.valid = out_v_q;
	assign rsp.select_n = out_q.select_n;
	assign rsp.serial_clock = out_q.serial_clock;
	assign rsp.command_line = out_q.command_line;
	assign rsp.busy_res = out_q.busy;
	assign rsp.done_res = out_q.done;
	assign rsp.mode_byte = out_q.mode;
	assign rsp.buttons_low = out_q.btn_lo;
	assign rsp.buttons_high = out_q.btn_hi;
	assign rsp.right_x = out_q.axis[0];
	assign rsp.right_y = out_q.axis[1];
	assign rsp.left_x = out_q.axis[2];
	assign rsp.left_y = out_q.axis[3];

endmodule

[rtl/core/gamepad_serial_poll_host_core.sv]
// ----------------------------------------------------------------------------
// Gamepad serial poll host core
// Host side of a serial gamepad link, stepped one timing tick per request.
// ----------------------------------------------------------------------------
// Each request is one timing tick and yields one report. The sequencer takes
// a request every cycle while its four-entry report queue has room. Reports
// leave the remap stage one per cycle while the receiver is ready and the
// four stick bytes and deadzone settings match the last computed set; when
// they change (after a stick byte is received or the deadzone is rewritten)
// the remap stage holds the next report while it sees the change and, per
// axis, picks a branch and, in an outer band, runs a 16-step serial divider.
module gamepad_serial_poll_host_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_write,
	input  logic [2:0] cfg_index,
	input  logic [9:0] cfg_data,
	gpsp_req_if.sink   req,
	gpsp_rsp_if.source rsp
);
	import gpsp_pkg::*;

	cfg_t cfg_q;
	logic q_full, q_push, q_empty, q_pop;
	rec_t wr_rec, rd_rec;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.deadzone <= 7'd10;
			cfg_q.deadzone_enable <= 1'b1;
			cfg_q.setup_ticks <= 8'd2;
			cfg_q.sample_ticks <= 8'd8;
			cfg_q.hold_ticks <= 8'd6;
			cfg_q.select_guard_ticks <= 10'd20;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_DEADZONE: cfg_q.deadzone <= cfg_data[6:0];
				REG_DZ_ENABLE: cfg_q.deadzone_enable <= cfg_data[0];
				REG_SETUP: cfg_q.setup_ticks <= cfg_data[7:0];
				REG_SAMPLE: cfg_q.sample_ticks <= cfg_data[7:0];
				REG_HOLD: cfg_q.hold_ticks <= cfg_data[7:0];
				REG_GUARD: cfg_q.select_guard_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

	gpsp_seq u_seq (
		.clk, .arst_n, .cfg(cfg_q), .req,
		.q_full, .q_push, .q_rec(wr_rec)
	);

	gpsp_queue u_queue (
		.clk, .arst_n, .push(q_push), .wr_rec, .full(q_full),
		.pop(q_pop), .empty(q_empty), .rd_rec
	);

	gpsp_remap u_remap (
		.clk, .arst_n, .cfg(cfg_q), .q_empty, .q_rec(rd_rec), .q_pop, .rsp
	);

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// Gamepad serial poll host testbench
// Drives timing ticks into the host core and checks every tick report
// against a predictor of the pin sequencer and the stick remap, tick by tick.
// ----------------------------------------------------------------------------
import gpsp_pkg::*;

// Sequencer phases of the predicted link.
typedef enum int {
	LNK_IDLE, LNK_SEL, LNK_LEAD, LNK_HIGH, LNK_LOW, LNK_HOLD, LNK_DESEL
} link_phase_t;

// One expected tick report.
typedef struct packed {
	logic       sel_n;
	logic       sclk;
	logic       cmd_line;
	logic       busy;
	logic       done;
	logic [7:0] mode;
	logic [7:0] btn_lo;
	logic [7:0] btn_hi;
	logic [7:0] rx;
	logic [7:0] ry;
	logic [7:0] lx;
	logic [7:0] ly;
} pad_report_t;

class PadLinkScoreboard;
	bit [6:0] dz;
	bit dz_en;
	bit [7:0] setup_t, sample_t, hold_t;
	bit [9:0] guard_t;
	link_phase_t lphase;
	int tcnt, bit_i, byte_i, step, op;
	bit [15:0] motors;
	bit [7:0] shift;
	bit [7:0] rx_bytes [9];
	bit [7:0] init_tab [7][9];
	pad_report_t pending_reports[$];
	int errors;

	function new();
		dz = 7'd10; dz_en = 1'b1; setup_t = 8'd2; sample_t = 8'd8; hold_t = 8'd6;
		guard_t = 10'd20;
		lphase = LNK_IDLE; tcnt = 0; bit_i = 0; byte_i = 0; step = 0; op = 0;
		motors = '0; shift = '0; errors = 0;
		foreach (rx_bytes[i]) rx_bytes[i] = 8'h00;
		init_tab = '{
			'{8'h01, 8'h42, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
			'{8'h01, 8'h42, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
			'{8'h01, 8'h42, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
			'{8'h01, 8'h43, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
			'{8'h01, 8'h44, 8'h00, 8'h01, 8'hEE, 8'h00, 8'h00, 8'h00, 8'h00},
			'{8'h01, 8'h4D, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00},
			'{8'h01, 8'h43, 8'h00, 8'h00, 8'h5A, 8'h5A, 8'h5A, 8'h5A, 8'h5A}};
	endfunction

	function void set_reg(logic [2:0] idx, logic [9:0] val);
		case (idx)
			REG_DEADZONE: dz = val[6:0];
			REG_DZ_ENABLE: dz_en = val[0];
			REG_SETUP: setup_t = val[7:0];
			REG_SAMPLE: sample_t = val[7:0];
			REG_HOLD: hold_t = val[7:0];
			REG_GUARD: guard_t = val;
			default: ;
		endcase
	endfunction

	function int frame_bytes_now();
		if (op == CMD_INIT && (step <= 2 || step == 5))
			return 5;
		return FRAME_BYTES;
	endfunction

	function bit [7:0] tx_byte();
		if (byte_i >= 9)
			return 8'h00;
		if (op == CMD_INIT)
			return init_tab[step < 7 ? step : 6][byte_i];
		if (byte_i == 0)
			return 8'h01;
		if (byte_i == 1)
			return 8'h42;
		if (op == CMD_VIBE && byte_i == 3)
			return motors[7:0];
		if (op == CMD_VIBE && byte_i == 4)
			return motors[15:8];
		return 8'h00;
	endfunction

	function int ticks_in_phase();
		int n;
		case (lphase)
			LNK_SEL, LNK_DESEL: n = guard_t;
			LNK_LEAD, LNK_HIGH: n = setup_t;
			LNK_LOW: n = sample_t;
			default: n = hold_t;
		endcase
		return (n == 0) ? 1 : n;
	endfunction

	// Deadzone remap of one stick axis.
	function bit [7:0] remap_axis(bit [7:0] v);
		int d;
		int x;
		d = dz;
		x = v;
		if (!dz_en)
			return v;
		if (x > 128 + d) begin
			if (d >= 127)
				return 8'd255;
			return 8'(128 + (x - 128 - d) * 127 / (127 - d));
		end
		if (x + d < 128)
			return 8'(x * 128 / (128 - d));
		return 8'd128;
	endfunction

	// Advances the link by one tick and queues the report it yields.
	function void note_tick(bit [1:0] cmd, bit [7:0] ml, bit [7:0] ms, bit din);
		pad_report_t r;
		bit last;
		bit [7:0] tbyte;
		if (lphase == LNK_IDLE && cmd != CMD_TICK) begin
			op = cmd;
			motors = {ms, ml};
			lphase = LNK_SEL;
			tcnt = 0; bit_i = 0; byte_i = 0; step = 0; shift = '0;
		end
		r = '0;
		r.sel_n = !(lphase != LNK_IDLE && lphase != LNK_DESEL);
		r.sclk = !(lphase == LNK_LOW || lphase == LNK_HOLD);
		r.busy = lphase != LNK_IDLE;
		if (lphase == LNK_HIGH || lphase == LNK_LOW || lphase == LNK_HOLD) begin
			tbyte = tx_byte();
			r.cmd_line = tbyte[bit_i[2:0]];
		end
		if (lphase != LNK_IDLE) begin
			last = tcnt + 1 >= ticks_in_phase();
			tcnt = last ? 0 : tcnt + 1;
			if (last) begin
				case (lphase)
					LNK_SEL: lphase = LNK_LEAD;
					LNK_LEAD: begin
						lphase = LNK_HIGH;
						bit_i = 0;
						shift = '0;
					end
					LNK_HIGH: lphase = LNK_LOW;
					LNK_LOW: begin
						shift[bit_i[2:0]] = din;
						lphase = LNK_HOLD;
					end
					LNK_HOLD: begin
						if (bit_i < 7) begin
							bit_i++;
							lphase = LNK_HIGH;
						end else begin
							if (op != CMD_INIT && byte_i < 9)
								rx_bytes[byte_i] = shift;
							byte_i = (byte_i + 1) & 15;
							bit_i = 0;
							lphase = (byte_i >= frame_bytes_now()) ? LNK_DESEL : LNK_LEAD;
						end
					end
					default: begin
						if (op == CMD_INIT && step < 6) begin
							step++;
							byte_i = 0;
							lphase = LNK_SEL;
						end else begin
							lphase = LNK_IDLE;
							r.done = 1'b1;
						end
					end
				endcase
			end
		end
		r.mode = rx_bytes[1];
		r.btn_lo = ~rx_bytes[3];
		r.btn_hi = ~rx_bytes[4];
		r.rx = remap_axis(rx_bytes[5]);
		r.ry = remap_axis(rx_bytes[6]);
		r.lx = remap_axis(rx_bytes[7]);
		r.ly = remap_axis(rx_bytes[8]);
		pending_reports.push_back(r);
	endfunction

	task mismatch(string msg);
		$display("ERROR: %s", msg);
		errors++;
	endtask

	task cmp(string nm, int got, int want);
		if (got != want)
			mismatch($sformatf("%s got 0x%0h expected 0x%0h", nm, got, want));
	endtask

	// Compares one accepted report with the oldest prediction.
	task check_report(pad_report_t got);
		pad_report_t w;
		if (pending_reports.size() == 0) begin
			mismatch("report arrived with nothing predicted");
		end else begin
			w = pending_reports.pop_front();
			cmp("select_n", got.sel_n, w.sel_n);
			cmp("serial_clock", got.sclk, w.sclk);
			cmp("command_line", got.cmd_line, w.cmd_line);
			cmp("busy_res", got.busy, w.busy);
			cmp("done_res", got.done, w.done);
			cmp("mode_byte", got.mode, w.mode);
			cmp("buttons_low", got.btn_lo, w.btn_lo);
			cmp("buttons_high", got.btn_hi, w.btn_hi);
			cmp("right_x", got.rx, w.rx);
			cmp("right_y", got.ry, w.ry);
			cmp("left_x", got.lx, w.lx);
			cmp("left_y", got.ly, w.ly);
		end
	endtask
endclass

module tb_top;
	localparam int STALL_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 100;

	logic clk;
	logic arst_n;
	logic cfg_write;
	logic [2:0] cfg_index;
	logic [9:0] cfg_data;
	int quiet_cycles;
	bit [7:0] line_pattern [9];

	gpsp_req_if req();
	gpsp_rsp_if rsp();
	PadLinkScoreboard sb;

	gamepad_serial_poll_host_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req(req.sink),
		.rsp(rsp.source)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// At least half the items go without a gap so that back-to-back runs occur.
	function int draw_gap();
		if ($urandom_range(0, 1) == 0)
			return 0;
		return $urandom_range(0, 16);
	endfunction

	// Sends one tick request and notes it once accepted.
	task send_tick(bit [1:0] cmd, bit [7:0] ml, bit [7:0] ms, bit din);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.command <= cmd;
		req.motor_large <= ml;
		req.motor_small <= ms;
		req.data_in <= din;
		do @(posedge clk); while (!req.ready);
		sb.note_tick(cmd, ml, ms, din);
	endtask

	// Stops requests and waits until every predicted report has come back.
	task drain();
		req.valid <= 1'b0;
		while (sb.pending_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task write_reg(logic [2:0] idx, int val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 10'(val);
		@(posedge clk);
		sb.set_reg(idx, 10'(val));
	endtask

	task configure(int dz, int en, int su, int sa, int ho, int gu);
		write_reg(REG_DEADZONE, dz);
		write_reg(REG_DZ_ENABLE, en);
		write_reg(REG_SETUP, su);
		write_reg(REG_SAMPLE, sa);
		write_reg(REG_HOLD, ho);
		write_reg(REG_GUARD, gu);
		cfg_write <= 1'b0;
	endtask

	// Runs one operation to its end. Line modes: 0 all low, 1 all high,
	// 2 a chosen reply frame with noise between sampling ticks.
	task run_op(bit [1:0] cmd, int line_mode);
		bit [7:0] ml, ms;
		bit din;
		int centered;
		ml = 8'($urandom_range(0, 255));
		ms = 8'($urandom_range(0, 255));
		foreach (line_pattern[i]) begin
			line_pattern[i] = 8'($urandom_range(0, 255));
			centered = 128 + $urandom_range(0, 2 * (sb.dz + 3)) - (sb.dz + 3);
			if (i >= 5 && $urandom_range(0, 1) == 1 && centered >= 0 && centered <= 255)
				line_pattern[i] = 8'(centered);
		end
		send_tick(cmd, ml, ms, line_mode == 1);
		while (sb.lphase != LNK_IDLE) begin
			if (line_mode == 2 && sb.lphase == LNK_LOW && sb.byte_i < 9)
				din = line_pattern[sb.byte_i][sb.bit_i];
			else if (line_mode == 2)
				din = 1'($urandom_range(0, 1));
			else
				din = line_mode == 1;
			// Requests during an operation are ignored, so any command fits.
			send_tick(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), din);
		end
		repeat ($urandom_range(0, 3))
			send_tick(CMD_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				1'($urandom_range(0, 1)));
	endtask

	// Receiver with random stalls.
	initial begin
		int stall;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp.valid && rsp.ready) begin
				sb.check_report({rsp.select_n, rsp.serial_clock, rsp.command_line,
					rsp.busy_res, rsp.done_res, rsp.mode_byte, rsp.buttons_low,
					rsp.buttons_high, rsp.right_x, rsp.right_y, rsp.left_x, rsp.left_y});
				stall = draw_gap();
				if (stall > 0) begin
					rsp.ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			rsp.ready <= 1'b1;
		end
	end

	// Watchdog on cycles without any accepted request or report.
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL gamepad_serial_poll_host_core");
			$finish;
		end
	end

	initial begin
		sb = new();
		quiet_cycles = 0;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_DEADZONE;
		cfg_data = '0;
		req.valid = 1'b0;
		req.command = CMD_TICK;
		req.motor_large = '0;
		req.motor_small = '0;
		req.data_in = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Minimum timing, no deadzone, all-high reply.
		configure(0, 1, 1, 1, 1, 1);
		run_op(CMD_POLL, 1);
		drain();
		// Remap disabled, vibration poll with a chosen reply.
		configure(10, 0, 1, 1, 1, 1);
		run_op(CMD_VIBE, 2);
		drain();
		// Zero tick registers act as one; widest deadzone over the init run.
		configure(127, 1, 0, 0, 0, 0);
		run_op(CMD_INIT, 2);
		drain();
		// Wide deadzone with uneven timing.
		configure(100, 1, 1, 2, 1, 3);
		run_op(CMD_POLL, 2);
		drain();

		if (sb.errors == 0 && sb.pending_reports.size() == 0)
			$display("PASS gamepad_serial_poll_host_core");
		else
			$display("FAIL gamepad_serial_poll_host_core");
		$finish;
	end
endmodule
